@@ hdl/xcmfp_pkg.sv @@
package xcmfp_pkg;

    // Configuration port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_TURN      = 3'd0;
    localparam logic [2:0] REG_NOTIFY    = 3'd1;
    localparam logic [2:0] REG_HEARTBEAT = 3'd2;
    localparam logic [2:0] REG_GPS       = 3'd3;
    localparam logic [2:0] REG_COMMAND   = 3'd4;

    // Reset values of the type codes
    localparam logic [7:0] TURN_CODE_RST      = 8'd1;
    localparam logic [7:0] NOTIFY_CODE_RST    = 8'd2;
    localparam logic [7:0] HEARTBEAT_CODE_RST = 8'd3;
    localparam logic [7:0] GPS_CODE_RST       = 8'd4;
    localparam logic [7:0] COMMAND_CODE_RST   = 8'd5;

    // Payload limits
    localparam logic [9:0] ROAD_NAME_MAX  = 10'd32;
    localparam logic [9:0] GPS_TEXT_MAX   = 10'd128;
    localparam logic [9:0] TITLE_CAPACITY = 10'd64;
    localparam logic [9:0] BODY_CAPACITY  = 10'd128;

    // Frame layout
    localparam logic [8:0] POS_TYPE     = 9'd0;
    localparam logic [8:0] POS_SEQ      = 9'd1;
    localparam logic [8:0] POS_LEN      = 9'd2;
    localparam logic [8:0] HEADER_LEN   = 9'd3;
    localparam logic [8:0] POS_MAX      = 9'd511;
    localparam logic [9:0] MIN_FRAME    = 10'd4;
    localparam logic [9:0] FRAME_EXTRA  = 10'd4;
    localparam logic [9:0] TURN_MIN_LEN = 10'd5;
    localparam logic [9:0] NOTIF_MIN    = 10'd3;
    localparam logic [9:0] HB_LEN       = 10'd5;
    localparam logic [9:0] CMD_MIN_LEN  = 10'd1;

    // Result kinds
    localparam logic RK_TEXT    = 1'b0;
    localparam logic RK_VERDICT = 1'b1;

    // Text field codes
    localparam logic [1:0] TF_ROAD  = 2'd0;
    localparam logic [1:0] TF_TITLE = 2'd1;
    localparam logic [1:0] TF_BODY  = 2'd2;
    localparam logic [1:0] TF_GPS   = 2'd3;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_LEN_MISMATCH = 3'd2,
        ST_CHECKSUM    = 3'd3,
        ST_UNKNOWN     = 3'd4,
        ST_BAD_PAYLOAD = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        K_TURN  = 3'd0,
        K_NOTIF = 3'd1,
        K_HB    = 3'd2,
        K_GPS   = 3'd3,
        K_CMD   = 3'd4,
        K_NONE  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] turn;
        logic [7:0] notify;
        logic [7:0] heartbeat;
        logic [7:0] gps;
        logic [7:0] command;
    } type_codes_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  text_field;
        logic [7:0]  text_byte;
        logic [2:0]  status;
        logic [7:0]  message_type;
        logic [7:0]  sequence_res;
        logic [7:0]  aux_code;
        logic [15:0] turn_distance;
        logic [7:0]  turn_exit;
        logic [31:0] hb_uptime;
    } out_word_t;

endpackage

@@ hdl/xor_checked_message_frame_parser_top.sv @@
// Streaming parser for XOR-checked frames (type, sequence, length, payload,
// checksum), one byte word per cycle. Each accepted byte is parsed in the
// same cycle it is taken; its result, if any (a text passthrough byte or
// the end-of-frame verdict), appears in the output register the next cycle.
// A byte is taken in every cycle in which the output register is empty or
// is being read, so the sustained rate is one byte per clock; the only limit
// is that single output register stalling behind the downstream side.
// Type codes are set through the APB registers (turn, notification,
// heartbeat, GPS, command at 0x00..0x10); write them only while idle.
module xor_checked_message_frame_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          frame_valid,
    output logic                          frame_stall,
    input  xcmfp_pkg::in_word_t           frame_word,
    output logic                          result_valid,
    input  logic                          result_stall,
    output xcmfp_pkg::out_word_t          result_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xcmfp_pkg::PADDR_W-1:0] paddr,
    input  logic [xcmfp_pkg::PDATA_W-1:0] pwdata,
    output logic [xcmfp_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import xcmfp_pkg::*;

    type_codes_t codes;
    logic        frame_accept;
    logic        res_valid;
    out_word_t   res_word;

    xcmfp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .codes   (codes)
    );

    xcmfp_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_accept (frame_accept),
        .frame_word   (frame_word),
        .codes        (codes),
        .res_valid    (res_valid),
        .res_word     (res_word)
    );

    xcmfp_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .result_stall (result_stall),
        .res_valid    (res_valid),
        .res_word     (res_word),
        .frame_stall  (frame_stall),
        .frame_accept (frame_accept),
        .result_valid (result_valid),
        .result_word  (result_word)
    );

endmodule

@@ hdl/xcmfp_cfg.sv @@
module xcmfp_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xcmfp_pkg::PADDR_W-1:0] paddr,
    input  logic [xcmfp_pkg::PDATA_W-1:0] pwdata,
    output logic [xcmfp_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output xcmfp_pkg::type_codes_t        codes
);
    import xcmfp_pkg::*;

    type_codes_t codes_reg;
    type_codes_t codes_next;
    logic        wr_en;
    logic [7:0]  rd_byte;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign codes  = codes_reg;

    // Decode the write
    always_comb
    begin
        codes_next = codes_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_TURN:      codes_next.turn      = pwdata[7:0];
                REG_NOTIFY:    codes_next.notify    = pwdata[7:0];
                REG_HEARTBEAT: codes_next.heartbeat = pwdata[7:0];
                REG_GPS:       codes_next.gps       = pwdata[7:0];
                REG_COMMAND:   codes_next.command   = pwdata[7:0];
                default:       codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.turn      <= TURN_CODE_RST;
            codes_reg.notify    <= NOTIFY_CODE_RST;
            codes_reg.heartbeat <= HEARTBEAT_CODE_RST;
            codes_reg.gps       <= GPS_CODE_RST;
            codes_reg.command   <= COMMAND_CODE_RST;
        end
        else
        begin
            codes_reg <= codes_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[4:2])
            REG_TURN:      rd_byte = codes_reg.turn;
            REG_NOTIFY:    rd_byte = codes_reg.notify;
            REG_HEARTBEAT: rd_byte = codes_reg.heartbeat;
            REG_GPS:       rd_byte = codes_reg.gps;
            REG_COMMAND:   rd_byte = codes_reg.command;
            default:       rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(PDATA_W-8){1'b0}}, rd_byte};

endmodule

@@ hdl/xcmfp_parse.sv @@
module xcmfp_parse (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_accept,
    input  xcmfp_pkg::in_word_t    frame_word,
    input  xcmfp_pkg::type_codes_t codes,
    output logic                   res_valid,
    output xcmfp_pkg::out_word_t   res_word
);
    import xcmfp_pkg::*;

    logic [8:0]  pos_reg,    pos_next;
    logic [7:0]  xor_reg,    xor_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  aux_reg,    aux_next;
    logic [15:0] dist_reg,   dist_next;
    logic [7:0]  exit_reg,   exit_next;
    logic [31:0] uptime_reg, uptime_next;
    logic [7:0]  f1_reg,     f1_next;
    logic [7:0]  f2_reg,     f2_next;

    kind_t       kind;
    logic [7:0]  b;
    logic [8:0]  idx;
    logic [9:0]  idx_w;
    logic [9:0]  f1_w;
    logic [9:0]  f2_w;
    logic [9:0]  len_w;
    logic [9:0]  flen;
    logic        in_payload;
    logic        payload_ok;
    status_t     st;

    assign b     = frame_word.frame_byte;
    assign idx   = pos_reg - HEADER_LEN;
    assign idx_w = {1'b0, idx};
    assign f1_w  = {2'b00, f1_reg};
    assign f2_w  = {2'b00, f2_reg};
    assign len_w = {2'b00, len_reg};
    assign flen  = {1'b0, pos_reg} + 10'd1;
    assign in_payload = (pos_reg >= HEADER_LEN) && (idx < {1'b0, len_reg});

    // Classify the stored type byte, first match wins
    always_comb
    begin
        priority if (type_reg == codes.turn)      kind = K_TURN;
        else if     (type_reg == codes.notify)    kind = K_NOTIF;
        else if     (type_reg == codes.heartbeat) kind = K_HB;
        else if     (type_reg == codes.gps)       kind = K_GPS;
        else if     (type_reg == codes.command)   kind = K_CMD;
        else                                      kind = K_NONE;
    end

    // Check the payload layout for the end-of-frame verdict
    always_comb
    begin
        unique case (kind)
            K_TURN:  payload_ok = !(len_w < TURN_MIN_LEN || f1_w > ROAD_NAME_MAX
                                    || TURN_MIN_LEN + f1_w != len_w);
            K_NOTIF: payload_ok = !(len_w < NOTIF_MIN || f1_w + NOTIF_MIN > len_w
                                    || f1_w >= TITLE_CAPACITY
                                    || NOTIF_MIN + f1_w + f2_w != len_w
                                    || f2_w >= BODY_CAPACITY);
            K_HB:    payload_ok = (len_w == HB_LEN);
            K_CMD:   payload_ok = !(len_w < CMD_MIN_LEN);
            default: payload_ok = 1'b1;
        endcase
    end

    // Pick the verdict
    always_comb
    begin
        priority if (flen < MIN_FRAME)                     st = ST_SHORT;
        else if     (flen != len_w + FRAME_EXTRA)          st = ST_LEN_MISMATCH;
        else if     ((xor_reg ^ b) != 8'd0)                st = ST_CHECKSUM;
        else if     (kind == K_NONE)                       st = ST_UNKNOWN;
        else if     (!payload_ok)                          st = ST_BAD_PAYLOAD;
        else                                               st = ST_OK;
    end

    // Advance the frame state and build the result word
    always_comb
    begin
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        aux_next    = aux_reg;
        dist_next   = dist_reg;
        exit_next   = exit_reg;
        uptime_next = uptime_reg;
        f1_next     = f1_reg;
        f2_next     = f2_reg;
        res_valid   = 1'b0;
        res_word    = '0;

        if (frame_accept && !frame_word.final_byte)
        begin
            xor_next = xor_reg ^ b;
            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 9'd1;
            // Bytes past the payload only advance the count and the checksum
            if (pos_reg == POS_TYPE)
            begin
                type_next = b;
            end
            else if (pos_reg == POS_SEQ)
            begin
                seq_next = b;
            end
            else if (pos_reg == POS_LEN)
            begin
                len_next = b;
            end
            else if (in_payload)
            begin
                // Capture fixed payload fields
                if (kind == K_HB)
                begin
                    if (idx < 9'd4)
                        uptime_next = uptime_reg | ({24'd0, b} << {idx[1:0], 3'b000});
                    else if (idx == 9'd4)
                        aux_next = b;
                end
                else
                begin
                    if (idx == 9'd0) aux_next = b;
                    if (idx == 9'd1) dist_next[7:0] = b;
                    if (idx == 9'd2) dist_next[15:8] = b;
                    if (idx == 9'd3) exit_next = b;
                    if (kind == K_TURN && idx == 9'd4) f1_next = b;
                    if (kind == K_NOTIF && idx == 9'd1) f1_next = b;
                    if (kind == K_NOTIF && idx >= 9'd2 && idx_w == 10'd2 + f1_w)
                        f2_next = b;
                end

                // Pass text bytes through
                res_word.result_kind = RK_TEXT;
                res_word.text_byte   = b;
                if (kind == K_TURN && idx >= 9'd5 && idx_w < 10'd5 + f1_w)
                begin
                    res_valid           = 1'b1;
                    res_word.text_field = TF_ROAD;
                end
                else if (kind == K_NOTIF && idx >= 9'd2 && idx_w < 10'd2 + f1_w)
                begin
                    res_valid           = 1'b1;
                    res_word.text_field = TF_TITLE;
                end
                else if (kind == K_NOTIF && idx_w >= 10'd3 + f1_w
                         && idx_w < 10'd3 + f1_w + f2_w)
                begin
                    res_valid           = 1'b1;
                    res_word.text_field = TF_BODY;
                end
                else if (kind == K_GPS && idx_w < GPS_TEXT_MAX)
                begin
                    res_valid           = 1'b1;
                    res_word.text_field = TF_GPS;
                end
                if (!res_valid)
                    res_word = '0;
            end
        end
        else if (frame_accept)
        begin
            // End of frame: report and drop all frame state
            res_valid            = 1'b1;
            res_word.result_kind = RK_VERDICT;
            res_word.status      = st;
            if (st == ST_OK || st == ST_UNKNOWN || st == ST_BAD_PAYLOAD)
            begin
                res_word.message_type = type_reg;
                res_word.sequence_res = seq_reg;
            end
            if (st == ST_OK)
            begin
                if (kind != K_GPS)
                    res_word.aux_code = aux_reg;
                if (kind == K_TURN)
                begin
                    res_word.turn_distance = dist_reg;
                    res_word.turn_exit     = exit_reg;
                end
                if (kind == K_HB)
                    res_word.hb_uptime = uptime_reg;
            end
            pos_next    = '0;
            xor_next    = '0;
            type_next   = '0;
            seq_next    = '0;
            len_next    = '0;
            aux_next    = '0;
            dist_next   = '0;
            exit_next   = '0;
            uptime_next = '0;
            f1_next     = '0;
            f2_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            xor_reg    <= '0;
            type_reg   <= '0;
            seq_reg    <= '0;
            len_reg    <= '0;
            aux_reg    <= '0;
            dist_reg   <= '0;
            exit_reg   <= '0;
            uptime_reg <= '0;
            f1_reg     <= '0;
            f2_reg     <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
            type_reg   <= type_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            aux_reg    <= aux_next;
            dist_reg   <= dist_next;
            exit_reg   <= exit_next;
            uptime_reg <= uptime_next;
            f1_reg     <= f1_next;
            f2_reg     <= f2_next;
        end
    end

    // A final word leaves a clean frame state behind
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_accept && frame_word.final_byte) |=> (pos_reg == '0 && xor_reg == '0))
        else $error("frame state not cleared after final word");

    // Position counts up by one per non-final word until it saturates
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_accept && !frame_word.final_byte && pos_reg != POS_MAX)
        |=> (pos_reg == $past(pos_reg) + 9'd1))
        else $error("byte position did not advance");

    // Every final word yields exactly one verdict
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_accept && frame_word.final_byte)
        |-> (res_valid && res_word.result_kind == RK_VERDICT))
        else $error("final word produced no verdict");

endmodule

@@ hdl/xcmfp_out.sv @@
module xcmfp_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    input  logic                 result_stall,
    input  logic                 res_valid,
    input  xcmfp_pkg::out_word_t res_word,
    output logic                 frame_stall,
    output logic                 frame_accept,
    output logic                 result_valid,
    output xcmfp_pkg::out_word_t result_word
);
    import xcmfp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // Take a new word whenever the result register is empty or draining
    assign frame_stall  = valid_reg && result_stall;
    assign frame_accept = frame_valid && !frame_stall;
    assign result_valid = valid_reg;
    assign result_word  = word_reg;

    always_comb
    begin
        if (frame_accept)
            valid_next = res_valid;
        else if (!result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (frame_accept && res_valid)
            word_reg <= res_word;
    end

    // A produced result is presented on the next cycle
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_accept && res_valid) |=> valid_reg)
        else $error("result lost at the output register");

endmodule
